// ===== rtl/tms_pkg.sv =====
`timescale 1ns / 1ps
// tms_pkg: shared types and constants of the template marker splitter.
// No dependencies; imported by the splitter modules.
package tms_pkg;

  typedef enum logic [1:0] {
    CFG_LEFT_MARKER  = 2'd0,
    CFG_LEFT_LENGTH  = 2'd1,
    CFG_RIGHT_MARKER = 2'd2,
    CFG_RIGHT_LENGTH = 2'd3
  } tms_cfg_index_t;

  localparam logic [31:0] LEFT_MARKER_RESET  = 32'd31611;
  localparam logic [2:0]  LEFT_LENGTH_RESET  = 3'd2;
  localparam logic [31:0] RIGHT_MARKER_RESET = 32'd32125;
  localparam logic [2:0]  RIGHT_LENGTH_RESET = 3'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_variable;
    logic       chunk_end;
    logic       missing_right;
    logic       whole_end;
    logic       run_last;
  } tms_result_t;

endpackage

// ===== rtl/tms_if.sv =====
`timescale 1ns / 1ps
// tms_in_if / tms_out_if: valid/ready channels of the template marker splitter.
// No dependencies.
interface tms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       string_end;

  modport source (output valid, text_byte, string_end, input ready);
  modport sink   (input valid, text_byte, string_end, output ready);
endinterface

interface tms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       in_variable;
  logic       chunk_end;
  logic       missing_right;
  logic       whole_end;
  logic       run_last;

  modport source (output valid, out_byte, byte_valid, in_variable, chunk_end,
                  missing_right, whole_end, run_last, input ready);
  modport sink   (input valid, out_byte, byte_valid, in_variable, chunk_end,
                  missing_right, whole_end, run_last, output ready);
endinterface

// ===== rtl/tms_cell.sv =====
`timescale 1ns / 1ps
// tms_cell: one byte position of the marker window with its compare.
// Depends on nothing; instantiated in a row by template_marker_splitter.
module tms_cell (
  input  logic       clk,
  input  logic       en,
  input  logic       wr,
  input  logic       shift,
  input  logic [7:0] in_byte,
  input  logic [7:0] right_cur,
  input  logic [7:0] mark_byte,
  input  logic       active,
  input  logic       match_in,
  output logic [7:0] cur,
  output logic [7:0] nxt,
  output logic       match_out
);

  logic [7:0] held;

  assign cur       = wr ? in_byte : held;
  assign nxt       = shift ? right_cur : cur;
  assign match_out = match_in & (!active || (cur == mark_byte));

  always_ff @(posedge clk) begin
    if (en) begin
      held <= nxt;
    end
  end

endmodule

// ===== rtl/tms_serializer.sv =====
`timescale 1ns / 1ps
// tms_serializer: holds one request's results, hands them out one per cycle
// unless the sink stalls, via an output register. Depends on tms_pkg and tms_if.
module tms_serializer import tms_pkg::*; #(
  parameter int DEPTH = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [$clog2(DEPTH+1)-1:0] load_count,
  input  tms_result_t                load_data [DEPTH],
  output logic                       can_load,
  tms_out_if.source                  chunk_out
);

  localparam int CW = $clog2(DEPTH + 1);

  tms_result_t   bundle [DEPTH];
  logic [CW-1:0] count;
  tms_result_t   out_q;
  logic          out_valid;
  logic          move;

  assign move     = (count != '0) && (!out_valid || chunk_out.ready);
  assign can_load = (count == '0) || ((count == CW'(1)) && move);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        count <= load_count;
      end else if (move) begin
        count <= count - CW'(1);
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (chunk_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_q <= bundle[0];
    end
    if (load) begin
      bundle <= load_data;
    end else if (move) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        bundle[j] <= bundle[j+1];
      end
    end
  end

  assign chunk_out.valid         = out_valid;
  assign chunk_out.out_byte      = out_q.out_byte;
  assign chunk_out.byte_valid    = out_q.byte_valid;
  assign chunk_out.in_variable   = out_q.in_variable;
  assign chunk_out.chunk_end     = out_q.chunk_end;
  assign chunk_out.missing_right = out_q.missing_right;
  assign chunk_out.whole_end     = out_q.whole_end;
  assign chunk_out.run_last      = out_q.run_last;

endmodule

// ===== rtl/template_marker_splitter.sv =====
`timescale 1ns / 1ps
// template_marker_splitter: top level of the template marker splitter.
// Depends on tms_pkg, tms_if, tms_cell and tms_serializer.
//
// Takes one template byte per cycle while the output is not stalled and
// splits the string into text and variable chunks between the left and right
// markers. A row of MAX_MARKER byte cells forms the delay window; all cells
// compare against the marker of the current mode in the same cycle, so a byte
// is accepted every cycle the output allows while each byte yields at most one
// result. A byte that ends the string yields up to MAX_MARKER + 1 results,
// which leave through the output register at one per cycle while the output is
// ready; input stalls until the last of them has moved to that register. A
// byte's results are held in the serializer bundle before the output register.
module template_marker_splitter import tms_pkg::*; #(
  parameter int MAX_MARKER = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  tms_in_if.sink      text_in,
  tms_out_if.source   chunk_out
);

  localparam int DEPTH = MAX_MARKER + 1;
  localparam int LW    = $clog2(MAX_MARKER + 1);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [31:0]   left_marker;
  logic [2:0]    left_length;
  logic [31:0]   right_marker;
  logic [2:0]    right_length;
  logic [LW-1:0] fill_count;
  logic          var_mode;
  logic          text_pending;

  logic [LW-1:0] eff_left;
  logic [LW-1:0] eff_right;
  logic [LW-1:0] len_a;
  logic [31:0]   marker_a;
  logic [LW-1:0] fill_g;
  logic [LW-1:0] fill1;
  logic          full;
  logic          match;
  logic          shift;
  logic          first;
  logic          var_a;
  logic          tp_a;
  logic [LW-1:0] fill_a;
  logic          last;
  logic          can_load;
  logic          accept;
  tms_result_t   first_res;
  tms_result_t   slots [DEPTH];
  logic [CW-1:0] n_total;

  logic [7:0] cur      [MAX_MARKER];
  logic [7:0] nxt      [MAX_MARKER];
  logic [7:0] right_in [MAX_MARKER];
  logic [7:0] mark_b   [MAX_MARKER];
  logic       active   [MAX_MARKER];
  logic       wr       [MAX_MARKER];
  logic [MAX_MARKER:0] mchain;
  logic [7:0] flush0   [DEPTH];
  logic [7:0] flush1   [DEPTH];

  assign last   = text_in.string_end;
  assign accept = text_in.valid && can_load;
  assign text_in.ready = can_load;

  always_comb begin
    if (left_length == 3'd0) begin
      eff_left = LW'(1);
    end else if (int'(left_length) > MAX_MARKER) begin
      eff_left = LW'(MAX_MARKER);
    end else begin
      eff_left = LW'(left_length);
    end
    if (right_length == 3'd0) begin
      eff_right = LW'(1);
    end else if (int'(right_length) > MAX_MARKER) begin
      eff_right = LW'(MAX_MARKER);
    end else begin
      eff_right = LW'(right_length);
    end
  end

  assign len_a    = var_mode ? eff_right : eff_left;
  assign marker_a = var_mode ? right_marker : left_marker;
  assign fill_g   = (fill_count >= len_a) ? '0 : fill_count;
  assign fill1    = fill_g + LW'(1);
  assign full     = (fill1 == len_a);
  assign match    = full && mchain[MAX_MARKER];
  assign shift    = full && !match;
  assign first    = shift || (match && (var_mode || text_pending));
  assign var_a    = match ? !var_mode : var_mode;
  assign tp_a     = match ? (var_mode && text_pending) : (text_pending || (shift && !var_mode));
  assign fill_a   = match ? '0 : (shift ? len_a - LW'(1) : fill1);

  assign mchain[0] = 1'b1;

  for (genvar k = 0; k < MAX_MARKER; k++) begin : g_cell
    assign wr[k]     = (fill_g == LW'(k));
    assign active[k] = (LW'(k) < len_a);
    if (k < 4) begin : g_mark
      assign mark_b[k] = marker_a[8*k +: 8];
    end else begin : g_nomark
      assign mark_b[k] = 8'd0;
    end
    if (k < MAX_MARKER - 1) begin : g_right
      assign right_in[k] = cur[k+1];
    end else begin : g_end
      assign right_in[k] = 8'd0;
    end

    tms_cell u_cell (
      .clk       (clk),
      .en        (accept),
      .wr        (wr[k]),
      .shift     (shift),
      .in_byte   (text_in.text_byte),
      .right_cur (right_in[k]),
      .mark_byte (mark_b[k]),
      .active    (active[k]),
      .match_in  (mchain[k]),
      .cur       (cur[k]),
      .nxt       (nxt[k]),
      .match_out (mchain[k+1])
    );
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_flush
    if (j < MAX_MARKER) begin : g_f0
      assign flush0[j] = nxt[j];
    end else begin : g_f0z
      assign flush0[j] = 8'd0;
    end
    if (j > 0) begin : g_f1
      assign flush1[j] = nxt[j-1];
    end else begin : g_f1z
      assign flush1[j] = 8'd0;
    end
  end

  always_comb begin
    first_res = '0;
    if (match) begin
      first_res.in_variable = var_mode;
      first_res.chunk_end   = 1'b1;
    end else begin
      first_res.out_byte    = cur[0];
      first_res.byte_valid  = 1'b1;
      first_res.in_variable = var_mode;
    end
  end

  always_comb begin
    logic [CW-1:0] nsofar;
    logic          tp_f;
    logic          fin;
    logic [CW-1:0] jj;
    nsofar  = CW'(first) + (last ? CW'(fill_a) : '0);
    tp_f    = tp_a || (!var_a && (fill_a != '0));
    fin     = last && (var_a || tp_f || (nsofar == '0));
    n_total = nsofar + CW'(fin);
    for (int j = 0; j < DEPTH; j++) begin
      jj       = CW'(j);
      slots[j] = '0;
      if (jj < CW'(first)) begin
        slots[j] = first_res;
      end else if (jj < nsofar) begin
        slots[j].out_byte    = first ? flush1[j] : flush0[j];
        slots[j].byte_valid  = 1'b1;
        slots[j].in_variable = var_a;
      end else if (fin && (jj == nsofar)) begin
        slots[j].in_variable   = var_a;
        slots[j].missing_right = var_a;
        slots[j].chunk_end     = !var_a && tp_f;
      end
      if (jj == n_total - CW'(1)) begin
        slots[j].run_last  = 1'b1;
        slots[j].whole_end = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_marker  <= LEFT_MARKER_RESET;
      left_length  <= LEFT_LENGTH_RESET;
      right_marker <= RIGHT_MARKER_RESET;
      right_length <= RIGHT_LENGTH_RESET;
      fill_count   <= '0;
      var_mode     <= 1'b0;
      text_pending <= 1'b0;
    end else if (cfg_we) begin
      unique case (tms_cfg_index_t'(cfg_index))
        CFG_LEFT_MARKER: begin
          left_marker <= cfg_data;
        end
        CFG_LEFT_LENGTH: begin
          left_length <= cfg_data[2:0];
          fill_count  <= '0;
        end
        CFG_RIGHT_MARKER: begin
          right_marker <= cfg_data;
        end
        CFG_RIGHT_LENGTH: begin
          right_length <= cfg_data[2:0];
          fill_count   <= '0;
        end
      endcase
    end else if (accept) begin
      if (last) begin
        fill_count   <= '0;
        var_mode     <= 1'b0;
        text_pending <= 1'b0;
      end else begin
        fill_count   <= fill_a;
        var_mode     <= var_a;
        text_pending <= tp_a;
      end
    end
  end

  tms_serializer #(
    .DEPTH (DEPTH)
  ) u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_count (n_total),
    .load_data  (slots),
    .can_load   (can_load),
    .chunk_out  (chunk_out)
  );

  a_whole_end_last: assert property (@(posedge clk) disable iff (rst)
    chunk_out.valid && chunk_out.whole_end |-> chunk_out.run_last)
    else $error("whole_end without run_last");

  a_missing_in_var: assert property (@(posedge clk) disable iff (rst)
    chunk_out.valid && chunk_out.missing_right |->
      chunk_out.in_variable && !chunk_out.chunk_end && !chunk_out.byte_valid)
    else $error("missing_right on a result outside a variable");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < LW'(MAX_MARKER))
    else $error("window fill out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last && !cfg_we |=> !var_mode && !text_pending && (fill_count == '0))
    else $error("state not cleared after string end");

endmodule

// ===== tb/tms_chunk_checker.sv =====
`timescale 1ns / 1ps
// tms_chunk_checker: predicts the chunk results of the template marker splitter
// from the accepted requests and register writes, and compares each result.
// Depends on tms_pkg.
module tms_chunk_checker import tms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        string_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        in_variable,
  input  logic        chunk_end,
  input  logic        missing_right,
  input  logic        whole_end,
  input  logic        run_last,
  output int          mismatch_count,
  output int          chunks_due
);

  tms_result_t expected_chunks[$];

  logic [31:0] left_mk;
  logic [2:0]  left_len;
  logic [31:0] right_mk;
  logic [2:0]  right_len;

  logic [7:0]  win[4];
  int unsigned fill;
  bit          var_on;
  bit          text_seen;

  function automatic int unsigned span(input logic [2:0] l);
    if (l == 3'd0) return 1;
    if (l > 3'd4) return 4;
    return l;
  endfunction

  function automatic tms_result_t chunk_item(input logic [7:0] b, input bit valid,
                                             input bit var_flag, input bit end_flag,
                                             input bit miss);
    tms_result_t r;
    r = '0;
    r.out_byte      = valid ? b : 8'd0;
    r.byte_valid    = valid;
    r.in_variable   = var_flag;
    r.chunk_end     = end_flag;
    r.missing_right = miss;
    return r;
  endfunction

  task automatic clear_window();
    foreach (win[k]) win[k] = 8'd0;
    fill      = 0;
    var_on    = 1'b0;
    text_seen = 1'b0;
  endtask

  task automatic predict_chunks(input logic [7:0] b, input bit last);
    tms_result_t step_q[$];
    logic [31:0] mk;
    int unsigned len;
    int unsigned k;
    bit          hit;

    mk  = var_on ? right_mk : left_mk;
    len = span(var_on ? right_len : left_len);
    if (fill >= len) fill = 0;
    win[fill] = b;
    fill++;

    if (fill == len) begin
      hit = 1'b1;
      for (k = 0; k < len; k++)
        if (win[k] != mk[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        fill = 0;
        if (var_on) begin
          step_q = {step_q, chunk_item(8'd0, 1'b0, 1'b1, 1'b1, 1'b0)};
          var_on = 1'b0;
        end else begin
          if (text_seen) step_q = {step_q, chunk_item(8'd0, 1'b0, 1'b0, 1'b1, 1'b0)};
          text_seen = 1'b0;
          var_on    = 1'b1;
        end
      end else begin
        step_q = {step_q, chunk_item(win[0], 1'b1, var_on, 1'b0, 1'b0)};
        if (!var_on) text_seen = 1'b1;
        for (k = 1; k < len; k++) win[k-1] = win[k];
        fill--;
      end
    end

    if (last) begin
      for (k = 0; k < fill && k < 4; k++) begin
        step_q = {step_q, chunk_item(win[k], 1'b1, var_on, 1'b0, 1'b0)};
        if (!var_on) text_seen = 1'b1;
      end
      if (var_on)
        step_q = {step_q, chunk_item(8'd0, 1'b0, 1'b1, 1'b0, 1'b1)};
      else if (text_seen)
        step_q = {step_q, chunk_item(8'd0, 1'b0, 1'b0, 1'b1, 1'b0)};
      if (step_q.size() == 0)
        step_q = {step_q, chunk_item(8'd0, 1'b0, 1'b0, 1'b0, 1'b0)};
      step_q[step_q.size()-1].whole_end = 1'b1;
      clear_window();
    end

    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
    expected_chunks = {expected_chunks, step_q};
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_chunk();
    tms_result_t want;
    if (expected_chunks.size() == 0) begin
      $error("unexpected result: out_byte %0h byte_valid %0b", out_byte, byte_valid);
      mismatch_count++;
    end else begin
      want = expected_chunks.pop_front();
      compare_field("out_byte", want.out_byte, out_byte);
      compare_field("byte_valid", want.byte_valid, byte_valid);
      compare_field("in_variable", want.in_variable, in_variable);
      compare_field("chunk_end", want.chunk_end, chunk_end);
      compare_field("missing_right", want.missing_right, missing_right);
      compare_field("whole_end", want.whole_end, whole_end);
      compare_field("run_last", want.run_last, run_last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_mk   = LEFT_MARKER_RESET;
      left_len  = LEFT_LENGTH_RESET;
      right_mk  = RIGHT_MARKER_RESET;
      right_len = RIGHT_LENGTH_RESET;
      clear_window();
      expected_chunks.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) compare_chunk();
      if (in_valid && in_ready) predict_chunks(text_byte, string_end);
      if (cfg_we) begin
        case (tms_cfg_index_t'(cfg_index))
          CFG_LEFT_MARKER:  left_mk = cfg_data;
          CFG_LEFT_LENGTH:  begin
            left_len = cfg_data[2:0];
            fill     = 0;
          end
          CFG_RIGHT_MARKER: right_mk = cfg_data;
          CFG_RIGHT_LENGTH: begin
            right_len = cfg_data[2:0];
            fill      = 0;
          end
          default: ;
        endcase
      end
    end
    chunks_due = expected_chunks.size();
  end

endmodule

// ===== tb/template_marker_splitter_tb.sv =====
`timescale 1ns / 1ps
// template_marker_splitter_tb: drives template strings and marker settings into
// the splitter and gives the verdict. Depends on tms_pkg, tms_if, the splitter
// RTL and tms_chunk_checker.
module template_marker_splitter_tb;
  import tms_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  tms_in_if  text_in();
  tms_out_if chunk_out();

  int mismatch_count;
  int chunks_due;

  bit squeeze;
  bit steady;
  int sent;

  logic [31:0] cur_lm;
  logic [31:0] cur_rm;
  logic [2:0]  cur_ll;
  logic [2:0]  cur_rl;

  logic [31:0] phase_lm[6];
  logic [31:0] phase_rm[6];
  logic [2:0]  phase_ll[6];
  logic [2:0]  phase_rl[6];

  template_marker_splitter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text_in   (text_in),
    .chunk_out (chunk_out)
  );

  tms_chunk_checker chunk_monitor (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (text_in.valid),
    .in_ready       (text_in.ready),
    .text_byte      (text_in.text_byte),
    .string_end     (text_in.string_end),
    .out_valid      (chunk_out.valid),
    .out_ready      (chunk_out.ready),
    .out_byte       (chunk_out.out_byte),
    .byte_valid     (chunk_out.byte_valid),
    .in_variable    (chunk_out.in_variable),
    .chunk_end      (chunk_out.chunk_end),
    .missing_right  (chunk_out.missing_right),
    .whole_end      (chunk_out.whole_end),
    .run_last       (chunk_out.run_last),
    .mismatch_count (mismatch_count),
    .chunks_due     (chunks_due)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int span(input logic [2:0] l);
    if (l == 3'd0) return 1;
    if (l > 3'd4) return 4;
    return l;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return cur_lm[8*$urandom_range(0, 3) +: 8];
    if (r < 6) return cur_rm[8*$urandom_range(0, 3) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = squeeze ? 0 : pick_gap();
    if (gap > 0) begin
      text_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_in.valid      <= 1'b1;
    text_in.text_byte  <= b;
    text_in.string_end <= last;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close && (i == s.len() - 1));
  endtask

  task automatic send_template();
    logic [7:0] bytes[$];
    int ln;
    int rn;
    int cut;
    int k;
    ln = span(cur_ll);
    rn = span(cur_rl);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) bytes = {bytes, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 4)) bytes = {bytes, pick_char()};
        cut = ($urandom_range(0, 9) == 0) ? ln - 1 : ln;
        for (k = 0; k < cut; k++) bytes = {bytes, cur_lm[8*k +: 8]};
        repeat ($urandom_range(0, 4)) bytes = {bytes, pick_char()};
        if ($urandom_range(0, 9) != 0)
          for (k = 0; k < rn; k++) bytes = {bytes, cur_rm[8*k +: 8]};
      end
      repeat ($urandom_range(0, 3)) bytes = {bytes, pick_char()};
    end
    if (bytes.size() == 0) bytes = {bytes, pick_char()};
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic set_reg(input tms_cfg_index_t idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  task automatic settle(input int tail);
    int guard;
    text_in.valid <= 1'b0;
    guard = 0;
    while (chunks_due != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (tail) @(negedge clk);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int len;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze) begin
        chunk_out.ready <= 1'b0;
        repeat (80) @(negedge clk);
        squeeze = 1'b0;
      end else begin
        len = pick_gap();
        if (len > 0) begin
          chunk_out.ready <= 1'b0;
          repeat (len) @(negedge clk);
        end
        chunk_out.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int start;
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    text_in.valid      = 1'b0;
    text_in.text_byte  = '0;
    text_in.string_end = 1'b0;
    chunk_out.ready    = 1'b0;
    squeeze            = 1'b0;
    steady             = 1'b0;
    sent               = 0;
    cur_lm             = LEFT_MARKER_RESET;
    cur_rm             = RIGHT_MARKER_RESET;
    cur_ll             = LEFT_LENGTH_RESET;
    cur_rl             = RIGHT_LENGTH_RESET;

    phase_lm[0] = LEFT_MARKER_RESET;  phase_ll[0] = LEFT_LENGTH_RESET;
    phase_rm[0] = RIGHT_MARKER_RESET; phase_rl[0] = RIGHT_LENGTH_RESET;
    phase_lm[1] = 32'h0000_0024;      phase_ll[1] = 3'd1;
    phase_rm[1] = 32'h0000_0024;      phase_rl[1] = 3'd1;
    phase_lm[2] = 32'h2D2D_213C;      phase_ll[2] = 3'd4;
    phase_rm[2] = 32'h003E_2D2D;      phase_rl[2] = 3'd3;
    phase_lm[3] = 32'h0000_0000;      phase_ll[3] = 3'd4;
    phase_rm[3] = 32'hFFFF_FFFF;      phase_rl[3] = 3'd4;
    phase_lm[4] = $urandom();         phase_ll[4] = 3'd0;
    phase_rm[4] = $urandom();         phase_rl[4] = 3'd7;
    phase_lm[5] = 32'hDEAD_2828;      phase_ll[5] = 3'd2;
    phase_rm[5] = 32'h55AA_0029;      phase_rl[5] = 3'd1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("a{{x}}b", 1'b1);
    send_text("{{}}", 1'b1);
    send_text("{{y", 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("{", 1'b1);
    // drop the held window bytes with a length write in the middle of a string
    send_text("z{", 1'b0);
    settle(8);
    set_reg(CFG_LEFT_LENGTH, 32'(LEFT_LENGTH_RESET));
    cfg_we <= 1'b0;
    send_text("{q", 1'b1);

    for (int p = 0; p < 6; p++) begin
      settle(8);
      cur_lm  = phase_lm[p];
      cur_ll  = phase_ll[p];
      cur_rm  = phase_rm[p];
      cur_rl  = phase_rl[p];
      steady  = (p == 1);
      set_reg(CFG_LEFT_MARKER, cur_lm);
      set_reg(CFG_LEFT_LENGTH, 32'(cur_ll));
      set_reg(CFG_RIGHT_MARKER, cur_rm);
      set_reg(CFG_RIGHT_LENGTH, 32'(cur_rl));
      cfg_we <= 1'b0;
      if (p == 2) squeeze = 1'b1;
      start = sent;
      while (sent - start < 45) send_template();
    end

    settle(20);
    if (mismatch_count == 0 && chunks_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
